// ----- hw/rtl/bph_pkg.sv -----
// ----------------------------------------------------------------------------
// bph_pkg
// Shared types and constants of the byte pair histogram.
// ----------------------------------------------------------------------------
package bph_pkg;

    localparam int BYTE_W    = 8;
    localparam int PAIR_SIDE = 256;
    localparam int ADDR_W    = 2 * BYTE_W;   // row and column of one counter
    localparam int OUT_W     = 32;
    localparam int OP_W      = 2;

    // request op codes
    localparam logic [OP_W-1:0] OP_DATA  = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    typedef enum logic [1:0] {
        ST_CLEAR,   // zeroing sweep after reset
        ST_IDLE,    // ready for a request
        ST_INC,     // counter read back, write incremented value
        ST_LOAD     // counter read back, hand it to the output register
    } t_bph_state;

    // controller -> datapath
    typedef struct packed {
        logic clr_wr;     // write zero at sweep address, advance sweep
        logic pair_rd;    // read counter at (previous byte, data byte)
        logic take_byte;  // data byte becomes previous byte
        logic restart;    // forget previous byte
        logic cnt_rd;     // read counter at (read row, read col)
        logic inc_wr;     // write saturated increment back
        logic out_load;   // load output register from read data
    } t_bph_cmd;

    // datapath -> controller
    typedef struct packed {
        logic have_previous;
        logic clr_done;   // sweep is at the last address
        logic out_free;   // output register can take a value this cycle
    } t_bph_stat;

endpackage

// ----- hw/rtl/bph_ctrl.sv -----
// ----------------------------------------------------------------------------
// bph_ctrl
// Controller: sequences clear sweep, counter updates and counter reads.
// ----------------------------------------------------------------------------
module bph_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic [bph_pkg::OP_W-1:0] i_op,
    input  bph_pkg::t_bph_stat       i_stat,
    output logic                     o_in_stall,
    output bph_pkg::t_bph_cmd        o_cmd
);

    bph_pkg::t_bph_state r_state;
    bph_pkg::t_bph_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bph_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            bph_pkg::ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = bph_pkg::ST_IDLE;
                end
            end
            bph_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    unique case (i_op)
                        bph_pkg::OP_DATA: begin
                            o_cmd.take_byte = 1'b1;
                            if (i_stat.have_previous) begin
                                o_cmd.pair_rd = 1'b1;
                                n_state       = bph_pkg::ST_INC;
                            end
                        end
                        bph_pkg::OP_START: begin
                            o_cmd.restart = 1'b1;
                        end
                        bph_pkg::OP_READ: begin
                            o_cmd.cnt_rd = 1'b1;
                            n_state      = bph_pkg::ST_LOAD;
                        end
                        default: begin
                            // unused code: dropped
                        end
                    endcase
                end
            end
            bph_pkg::ST_INC: begin
                o_cmd.inc_wr = 1'b1;
                n_state      = bph_pkg::ST_IDLE;
            end
            bph_pkg::ST_LOAD: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = bph_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bph_pkg::ST_IDLE;
            end
        endcase
    end

    // the sweep runs once per reset
    a_clear_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != bph_pkg::ST_CLEAR) |=> (r_state != bph_pkg::ST_CLEAR))
        else $error("clear sweep re-entered");

endmodule

// ----- hw/rtl/bph_dp.sv -----
// ----------------------------------------------------------------------------
// bph_dp
// Datapath: counter memory, previous byte, saturating increment, output reg.
// ----------------------------------------------------------------------------
module bph_dp #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bph_pkg::t_bph_cmd            i_cmd,
    input  logic [bph_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic [bph_pkg::BYTE_W-1:0]   i_read_row,
    input  logic [bph_pkg::BYTE_W-1:0]   i_read_col,
    input  logic                         i_out_stall,
    output bph_pkg::t_bph_stat           o_stat,
    output logic                         o_out_valid,
    output logic [bph_pkg::OUT_W-1:0]    o_pair_count
);

    localparam int DEPTH = bph_pkg::PAIR_SIDE * bph_pkg::PAIR_SIDE;

    logic [COUNT_WIDTH-1:0] r_mem [DEPTH];

    logic [bph_pkg::ADDR_W-1:0] r_clr_addr;
    logic [bph_pkg::ADDR_W-1:0] r_addr;     // address held for write-back
    logic [bph_pkg::BYTE_W-1:0] r_prev;
    logic                       r_have_prev;
    logic [COUNT_WIDTH-1:0]     r_rdata;
    logic                       r_out_valid;
    logic [bph_pkg::OUT_W-1:0]  r_pair_count;

    logic [bph_pkg::ADDR_W-1:0] n_addr;
    logic [COUNT_WIDTH-1:0]     n_wdata;
    logic                       n_we;
    logic                       n_re;
    logic [COUNT_WIDTH-1:0]     n_inc;
    logic                       n_out_free;

    assign n_out_free = !r_out_valid || !i_out_stall;
    assign n_inc      = (&r_rdata) ? r_rdata : r_rdata + 1'b1;
    assign n_re       = i_cmd.pair_rd || i_cmd.cnt_rd;
    assign n_we       = i_cmd.clr_wr || i_cmd.inc_wr;

    always_comb begin
        n_addr  = r_addr;
        n_wdata = n_inc;
        priority if (i_cmd.clr_wr) begin
            n_addr  = r_clr_addr;
            n_wdata = '0;
        end else if (i_cmd.pair_rd) begin
            n_addr = {r_prev, i_data_byte};
        end else if (i_cmd.cnt_rd) begin
            n_addr = {i_read_row, i_read_col};
        end else begin
            n_addr = r_addr;
        end
    end

    // single port counter store
    always_ff @(posedge i_clk) begin
        if (n_we) begin
            r_mem[n_addr] <= n_wdata;
        end
        if (n_re) begin
            r_rdata <= r_mem[n_addr];
            r_addr  <= n_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_prev      <= '0;
            r_have_prev <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.take_byte) begin
                r_prev      <= i_data_byte;
                r_have_prev <= 1'b1;
            end else if (i_cmd.restart) begin
                r_have_prev <= 1'b0;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_pair_count <= bph_pkg::OUT_W'(r_rdata);
        end
    end

    assign o_stat.have_previous = r_have_prev;
    assign o_stat.clr_done      = &r_clr_addr;
    assign o_stat.out_free      = n_out_free;
    assign o_out_valid          = r_out_valid;
    assign o_pair_count         = r_pair_count;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("result overwrote a pending one");

    a_inc_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.inc_wr |-> $past(i_cmd.pair_rd))
        else $error("write-back without a preceding counter read");

    a_no_out_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr_wr |-> !r_out_valid)
        else $error("result pending during clear sweep");

endmodule

// ----- hw/rtl/byte_pair_histogram_core.sv -----
// ----------------------------------------------------------------------------
// byte_pair_histogram_core
// Saturating 256 x 256 histogram of adjacent byte pairs in a byte stream.
// ----------------------------------------------------------------------------
// After reset the block zeroes its 65536 counters, one per cycle, and holds
// o_in_stall high for the whole sweep. Then a start request (op 1) or an
// unused code is done in the state ST_IDLE alone; so is the first byte of
// a stream (op 0), while any later byte goes on to ST_INC, since its counter
// is read and then written back through the single port of the counter
// store; a counter read (op 2) goes on to ST_LOAD and waits there while the
// output register is still held by an earlier result. One request is in
// work at a time. A finished result sits in the output register, so the
// next request is taken while that result waits. Counters stop at
// 2^COUNT_WIDTH - 1; o_pair_count carries the low 32 bits of a counter.
// ----------------------------------------------------------------------------
module byte_pair_histogram_core #(
    parameter int COUNT_WIDTH = 32   // 8 .. 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [bph_pkg::OP_W-1:0]    i_op,
    input  logic [bph_pkg::BYTE_W-1:0]  i_data_byte,
    input  logic [bph_pkg::BYTE_W-1:0]  i_read_row,
    input  logic [bph_pkg::BYTE_W-1:0]  i_read_col,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [bph_pkg::OUT_W-1:0]   o_pair_count
);

    bph_pkg::t_bph_cmd  cmd;    // controller commands
    bph_pkg::t_bph_stat stat;   // datapath status

    // state machine: clear sweep, then accept/read/write-back sequencing
    bph_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // counter store, previous byte tracking, output register
    bph_dp #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_data_byte  (i_data_byte),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .i_out_stall  (i_out_stall),
        .o_stat       (stat),
        .o_out_valid  (o_out_valid),
        .o_pair_count (o_pair_count)
    );

endmodule

// ----- dv/tb_byte_pair_histogram_core.sv -----
// ----------------------------------------------------------------------------
// tb_byte_pair_histogram_core
// Self-checking testbench of the byte pair histogram core.
// ----------------------------------------------------------------------------
// Requests go in through a bursty sender. A behavioral histogram tracks every
// accepted request and queues the count that each read request must return.
// A checker pops that queue for each accepted result. The result side stalls
// on its own random pattern. Counters are built at the default width.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_byte_pair_histogram_core;

    // default counter width; saturation is only reached when this is narrow
    localparam int COUNT_W      = 32;
    localparam int PAIR_CELLS   = bph_pkg::PAIR_SIDE * bph_pkg::PAIR_SIDE;
    localparam int RANDOM_ITEMS = 740;
    localparam int MAX_REPORTS  = 10;
    localparam logic [bph_pkg::OP_W-1:0] OP_UNUSED = 2'd3;   // ignored by the block

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic [bph_pkg::OP_W-1:0]    op;
    logic [bph_pkg::BYTE_W-1:0]  data_byte;
    logic [bph_pkg::BYTE_W-1:0]  read_row;
    logic [bph_pkg::BYTE_W-1:0]  read_col;
    logic                        out_valid;
    logic                        out_stall;
    logic [bph_pkg::OUT_W-1:0]   pair_count;

    byte_pair_histogram_core #(
        .COUNT_WIDTH (COUNT_W)
    ) DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_op         (op),
        .i_data_byte  (data_byte),
        .i_read_row   (read_row),
        .i_read_col   (read_col),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_pair_count (pair_count)
    );

    // ------------------------------------------------------------------
    // Behavioral histogram and the counts that reads must still return
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0]          hist_counts [PAIR_CELLS];
    logic [bph_pkg::BYTE_W-1:0]  hist_prev_byte;
    logic                        hist_have_prev;
    logic [bph_pkg::OUT_W-1:0]   pending_counts [$];
    logic [bph_pkg::ADDR_W-1:0]  touched_pairs [$];   // recently counted pairs, for reads

    // run statistics
    int n_data, n_start, n_read, n_ignored, n_checked, n_saturated;
    int err_count;

    // sender / receiver pacing knobs
    bit src_idle_en;
    bit sink_stall_en;
    int src_burst_left;
    int sink_run_left;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: 10 ms leaves a wide margin over the clear sweep and the
    // stimulus, even with the longest gaps and stalls.
    initial begin
        #10_000_000;
        $display("Timeout with %0d results outstanding", pending_counts.size());
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Histogram update for one accepted request
    // ------------------------------------------------------------------
    task automatic hist_apply(input logic [bph_pkg::OP_W-1:0] req_op,
                              input logic [bph_pkg::BYTE_W-1:0] req_byte,
                              input logic [bph_pkg::BYTE_W-1:0] req_row,
                              input logic [bph_pkg::BYTE_W-1:0] req_col);
        logic [bph_pkg::ADDR_W-1:0] addr;
        logic [63:0]                wide;
        case (req_op)
            bph_pkg::OP_DATA: begin
                n_data++;
                // first byte of a stream is only remembered
                if (hist_have_prev) begin
                    addr = {hist_prev_byte, req_byte};
                    if (hist_counts[addr] != '1)
                        hist_counts[addr] = hist_counts[addr] + 1'b1;
                    else
                        n_saturated++;
                    touched_pairs.push_back(addr);
                    if (touched_pairs.size() > 32)
                        void'(touched_pairs.pop_front());
                end
                hist_prev_byte = req_byte;
                hist_have_prev = 1'b1;
            end
            bph_pkg::OP_START: begin
                n_start++;
                hist_have_prev = 1'b0;
            end
            bph_pkg::OP_READ: begin
                n_read++;
                addr = {req_row, req_col};
                wide = 64'(hist_counts[addr]);
                pending_counts.push_back(wide[bph_pkg::OUT_W-1:0]);
            end
            default: n_ignored++;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Send one request. Entered and left at a falling edge.
    // ------------------------------------------------------------------
    task automatic send_request(input logic [bph_pkg::OP_W-1:0] req_op,
                                input logic [bph_pkg::BYTE_W-1:0] req_byte,
                                input logic [bph_pkg::BYTE_W-1:0] req_row,
                                input logic [bph_pkg::BYTE_W-1:0] req_col);
        int gap;
        in_valid  <= 1'b1;
        op        <= req_op;
        data_byte <= req_byte;
        read_row  <= req_row;
        read_col  <= req_col;
        do @(posedge clk); while (in_stall);
        hist_apply(req_op, req_byte, req_row, req_col);
        @(negedge clk);
        if (src_idle_en) begin
            if (src_burst_left == 0) begin
                // gap between bursts; payload wanders while valid is low
                gap = $urandom_range(1, 6);
                in_valid <= 1'b0;
                repeat (gap) begin
                    op        <= bph_pkg::OP_W'($urandom);
                    data_byte <= bph_pkg::BYTE_W'($urandom);
                    read_row  <= bph_pkg::BYTE_W'($urandom);
                    read_col  <= bph_pkg::BYTE_W'($urandom);
                    @(negedge clk);
                end
                src_burst_left = $urandom_range(1, 12);
            end else begin
                src_burst_left--;
            end
        end
    endtask

    task automatic send_data(input logic [bph_pkg::BYTE_W-1:0] b);
        send_request(bph_pkg::OP_DATA, b, bph_pkg::BYTE_W'($urandom),
                     bph_pkg::BYTE_W'($urandom));
    endtask

    task automatic send_start();
        send_request(bph_pkg::OP_START, bph_pkg::BYTE_W'($urandom),
                     bph_pkg::BYTE_W'($urandom), bph_pkg::BYTE_W'($urandom));
    endtask

    task automatic send_read(input logic [bph_pkg::BYTE_W-1:0] row,
                             input logic [bph_pkg::BYTE_W-1:0] col);
        send_request(bph_pkg::OP_READ, bph_pkg::BYTE_W'($urandom), row, col);
    endtask

    // ------------------------------------------------------------------
    // Result receiver: stall runs and free runs of random length
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (sink_run_left != 0) begin
            sink_run_left <= sink_run_left - 1;
        end else if (sink_stall_en && !out_stall) begin
            out_stall     <= 1'b1;
            sink_run_left <= $urandom_range(0, 5);
        end else begin
            out_stall     <= 1'b0;
            sink_run_left <= $urandom_range(0, 9);
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    function automatic void log_mismatch(input string what,
                                         input logic [bph_pkg::OUT_W-1:0] exp_val,
                                         input logic [bph_pkg::OUT_W-1:0] act_val);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("%0t: %s: pair_count expected %0d, got %0d",
                     $realtime, what, exp_val, act_val);
    endfunction

    logic [bph_pkg::OUT_W-1:0] head_count;

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_counts.size() == 0) begin
                log_mismatch("result with no read pending", '0, pair_count);
            end else begin
                head_count = pending_counts.pop_front();
                n_checked++;
                if (pair_count !== head_count)
                    log_mismatch("count mismatch", head_count, pair_count);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // stream basics, extreme bytes, and reads at the table corners
    task automatic test_pair_counting();
        send_data(8'h00);           // first byte of the stream: nothing counted
        send_read(8'h00, 8'h00);
        send_data(8'hFF);
        send_data(8'hFF);
        send_data(8'h00);
        send_read(8'h00, 8'hFF);
        send_read(8'hFF, 8'hFF);
        send_read(8'hFF, 8'h00);
        send_read(8'h00, 8'h00);
    endtask

    // start forgets the previous byte but keeps the counts
    task automatic test_start_request();
        send_start();
        send_data(8'h5A);           // must not pair with the 00 before the start
        send_read(8'h00, 8'h5A);
        send_start();
        send_start();
        send_data(8'hA5);
        send_read(8'h5A, 8'hA5);
        send_read(8'hFF, 8'h00);    // survives the starts
    endtask

    // op code 3 changes nothing, not even the previous byte
    task automatic test_unused_op();
        send_data(8'h3C);
        send_request(OP_UNUSED, 8'h11, 8'h3C, 8'h11);
        send_data(8'h22);
        send_read(8'h3C, 8'h22);
        send_read(8'h11, 8'h22);
        send_read(8'hA5, 8'h11);
    endtask

    // one pair counted many times in a row, with reads along the way;
    // runs past the counter maximum when counters are narrow
    task automatic test_saturation();
        logic [bph_pkg::BYTE_W-1:0] b;
        int                         len;
        b   = bph_pkg::BYTE_W'($urandom);
        len = (COUNT_W <= 10) ? (1 << COUNT_W) + 4 : 40;
        send_start();
        for (int i = 0; i < len; i++) begin
            send_data(b);
            if (i % 37 == 36)
                send_read(b, b);
        end
        send_read(b, b);
        send_data(b);
        send_read(b, b);
    endtask

    // mostly well-formed streams with random content, reads biased to live pairs
    task automatic test_random_stream();
        logic [bph_pkg::BYTE_W-1:0] alphabet [4];
        logic [bph_pkg::ADDR_W-1:0] addr;
        int                         counted;
        int                         pick;
        counted = 0;
        foreach (alphabet[i])
            alphabet[i] = bph_pkg::BYTE_W'($urandom);
        while (counted < RANDOM_ITEMS) begin
            if (counted % 120 == 0) begin
                // new pacing phase, now and then with no idling at all
                src_idle_en   = ($urandom_range(0, 3) != 0);
                sink_stall_en = ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 1))
                    alphabet[$urandom_range(0, 3)] = bph_pkg::BYTE_W'($urandom);
            end
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                if ($urandom_range(0, 1))
                    send_data(alphabet[$urandom_range(0, 3)]);
                else
                    send_data(bph_pkg::BYTE_W'($urandom));
            end else if (pick < 62) begin
                send_start();
            end else if (pick < 95) begin
                pick = $urandom_range(0, 99);
                if (pick < 60 && touched_pairs.size() != 0)
                    addr = touched_pairs[$urandom_range(0, touched_pairs.size() - 1)];
                else if (pick < 85)
                    addr = {alphabet[$urandom_range(0, 3)], alphabet[$urandom_range(0, 3)]};
                else
                    addr = bph_pkg::ADDR_W'($urandom);
                send_read(addr[bph_pkg::ADDR_W-1:bph_pkg::BYTE_W],
                          addr[bph_pkg::BYTE_W-1:0]);
            end else begin
                // ignored code: noise, not counted toward the item total
                send_request(OP_UNUSED, bph_pkg::BYTE_W'($urandom),
                             bph_pkg::BYTE_W'($urandom), bph_pkg::BYTE_W'($urandom));
                counted--;
            end
            counted++;
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        op             = bph_pkg::OP_DATA;
        data_byte      = '0;
        read_row       = '0;
        read_col       = '0;
        out_stall      = 1'b0;
        src_idle_en    = 1'b1;
        sink_stall_en  = 1'b1;
        src_burst_left = 0;
        sink_run_left  = 0;
        err_count      = 0;
        n_data         = 0;
        n_start        = 0;
        n_read         = 0;
        n_ignored      = 0;
        n_checked      = 0;
        n_saturated    = 0;
        foreach (hist_counts[i])
            hist_counts[i] = '0;
        hist_prev_byte = '0;
        hist_have_prev = 1'b0;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // requests wait out the clearing sweep through in_stall
        test_pair_counting();
        test_start_request();
        test_unused_op();
        test_saturation();
        test_random_stream();

        // drain, then wait on to catch stray results
        in_valid <= 1'b0;
        while (pending_counts.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Covered %0d data bytes, %0d starts, %0d reads, %0d ignored codes",
                 n_data, n_start, n_read, n_ignored);
        $display("%0d counts checked, %0d increments held at saturation, %0d errors",
                 n_checked, n_saturated, err_count);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/bph_pkg.sv
hw/rtl/bph_ctrl.sv
hw/rtl/bph_dp.sv
hw/rtl/byte_pair_histogram_core.sv
dv/tb_byte_pair_histogram_core.sv
